/* hw/rtl/bgr_pkg.sv */
// shared constants and types of the graph reachability engine
package bgr_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int IDX_W        = $clog2(MAX_EDGES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int CNT_W        = VTX_W + 1;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [VTX_W-1:0]  tail;
        logic [VTX_W-1:0]  head;
        logic [LINK_W-1:0] flink;
        logic [LINK_W-1:0] rlink;
    } edge_t;

endpackage

/* hw/rtl/bgr_if.sv */
// command and response channel interfaces
interface bgr_cmd_if import bgr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [VTX_W-1:0] node_a;
    logic [VTX_W-1:0] node_b;
    modport source (output valid, mode, node_a, node_b, input ready);
    modport sink (input valid, mode, node_a, node_b, output ready);
endinterface

interface bgr_rsp_if ();
    logic       valid;
    logic       ready;
    logic       path_found;
    logic [1:0] status;
    modport source (output valid, path_found, status, input ready);
    modport sink (input valid, path_found, status, output ready);
endinterface

/* hw/rtl/bidirectional_graph_reachability.sv */
// graph reachability engine: edge store, list heads and bidirectional search
//
// channel   dir  payload                   handshake
// cmd       in   mode, node_a, node_b      valid/ready
// rsp       out  path_found, status        valid/ready
// cfg       in   vertex_count              vertex_count_we
//
// append: head read, store write, result; bad vertex, full store, mode 3: result only
// clear: one head entry per cycle; the same sweep runs after reset
// query: mark sweep, then queue and head read per vertex, edge and mark read per edge
// one item at a time; a result waits in the output register until taken
module bidirectional_graph_reachability import bgr_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vertex_count_we,
    input  logic [10:0]  vertex_count_wdata,
    bgr_cmd_if.sink      cmd,
    bgr_rsp_if.source    rsp
);

    typedef enum logic [3:0] {
        S_HCLR, S_IDLE, S_APP, S_MCLR, S_LOOP, S_NEXT, S_QRD, S_HRD,
        S_EDGE, S_ERD, S_SRD, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [10:0]         vc_reg;
    logic [VTX_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic [VTX_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [LINK_W-1:0]   edges_reg, edges_next;
    logic [CNT_W-1:0]    rs_reg, rs_next, ws_reg, ws_next, rt_reg, rt_next, wt_reg, wt_next;
    logic                side_reg, side_next;
    logic [LINK_W-1:0]   link_reg, link_next;
    logic [VTX_W-1:0]    nb_reg, nb_next;
    logic                found_reg, found_next;
    logic [1:0]          stat_reg, stat_next;
    logic                ov_reg, ov_next;
    logic                of_reg, of_next;
    logic [1:0]          os_reg, os_next;

    logic [LINK_W-1:0]   fh_mem [MAX_VERTICES];
    logic [LINK_W-1:0]   rh_mem [MAX_VERTICES];
    edge_t               edge_mem [MAX_EDGES];
    logic                ss_mem [MAX_VERTICES];
    logic                st_mem [MAX_VERTICES];
    logic [VTX_W-1:0]    qs_mem [MAX_VERTICES];
    logic [VTX_W-1:0]    qt_mem [MAX_VERTICES];

    logic [VTX_W-1:0]    fh_ra, rh_ra, fh_wa, rh_wa, s_ra, ss_wa, st_wa;
    logic [VTX_W-1:0]    qs_ra, qt_ra, qs_wa, qt_wa, qs_wd, qt_wd;
    logic [LINK_W-1:0]   fh_wd, rh_wd, fh_rd, rh_rd;
    logic                fh_we, rh_we, ss_we, st_we, qs_we, qt_we, e_we;
    logic                ss_wd, st_wd, ss_rd, st_rd;
    logic [IDX_W-1:0]    e_ra, e_wa;
    edge_t               e_wd, e_rd;
    logic [VTX_W-1:0]    qs_rd, qt_rd;
    logic [10:0]         lim;
    logic                a_bad, b_bad, other_seen, mine_seen;

    always_ff @(posedge clk)
    begin
        if (fh_we)
            fh_mem[fh_wa] <= fh_wd;
        fh_rd <= fh_mem[fh_ra];
        if (rh_we)
            rh_mem[rh_wa] <= rh_wd;
        rh_rd <= rh_mem[rh_ra];
        if (e_we)
            edge_mem[e_wa] <= e_wd;
        e_rd <= edge_mem[e_ra];
        if (ss_we)
            ss_mem[ss_wa] <= ss_wd;
        ss_rd <= ss_mem[s_ra];
        if (st_we)
            st_mem[st_wa] <= st_wd;
        st_rd <= st_mem[s_ra];
        if (qs_we)
            qs_mem[qs_wa] <= qs_wd;
        qs_rd <= qs_mem[qs_ra];
        if (qt_we)
            qt_mem[qt_wa] <= qt_wd;
        qt_rd <= qt_mem[qt_ra];
    end

    assign lim        = (vc_reg > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES) : vc_reg;
    assign a_bad      = {1'b0, cmd.node_a} >= lim;
    assign b_bad      = {1'b0, cmd.node_b} >= lim;
    assign other_seen = side_reg ? ss_rd : st_rd;
    assign mine_seen  = side_reg ? st_rd : ss_rd;

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.path_found = of_reg;
    assign rsp.status     = os_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        edges_next = edges_reg;
        rs_next    = rs_reg;
        ws_next    = ws_reg;
        rt_next    = rt_reg;
        wt_next    = wt_reg;
        side_next  = side_reg;
        link_next  = link_reg;
        nb_next    = nb_reg;
        found_next = found_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg && !rsp.ready;
        of_next    = of_reg;
        os_next    = os_reg;

        fh_ra = a_reg;
        rh_ra = b_reg;
        fh_we = 1'b0;
        rh_we = 1'b0;
        fh_wa = a_reg;
        rh_wa = b_reg;
        fh_wd = edges_reg + LINK_W'(1);
        rh_wd = edges_reg + LINK_W'(1);
        e_we  = 1'b0;
        e_wa  = edges_reg[IDX_W-1:0];
        e_wd  = '{tail: a_reg, head: b_reg, flink: fh_rd, rlink: rh_rd};
        e_ra  = IDX_W'(link_reg - LINK_W'(1));
        s_ra  = nb_reg;
        ss_we = 1'b0;
        st_we = 1'b0;
        ss_wa = nb_reg;
        st_wa = nb_reg;
        ss_wd = 1'b1;
        st_wd = 1'b1;
        qs_ra = rs_reg[VTX_W-1:0];
        qt_ra = rt_reg[VTX_W-1:0];
        qs_we = 1'b0;
        qt_we = 1'b0;
        qs_wa = ws_reg[VTX_W-1:0];
        qt_wa = wt_reg[VTX_W-1:0];
        qs_wd = nb_reg;
        qt_wd = nb_reg;

        case (state_reg)
            S_HCLR:
            begin
                fh_we = 1'b1;
                rh_we = 1'b1;
                fh_wa = cnt_reg;
                rh_wa = cnt_reg;
                fh_wd = '0;
                rh_wd = '0;
                cnt_next = cnt_reg + VTX_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = pend_reg ? S_DONE : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                fh_ra = cmd.node_a;
                rh_ra = cmd.node_b;
                if (cmd.valid)
                begin
                    a_next     = cmd.node_a;
                    b_next     = cmd.node_b;
                    found_next = 1'b0;
                    stat_next  = ST_OK;
                    cnt_next   = '0;
                    state_next = S_DONE;
                    if (cmd.mode == MODE_APPEND || cmd.mode == MODE_QUERY)
                    begin
                        if (a_bad || b_bad)
                            stat_next = ST_RANGE;
                        else if (cmd.mode == MODE_APPEND)
                        begin
                            if (edges_reg >= LINK_W'(MAX_EDGES))
                                stat_next = ST_FULL;
                            else
                                state_next = S_APP;
                        end
                        else if (cmd.node_a == cmd.node_b)
                            found_next = 1'b1;
                        else
                            state_next = S_MCLR;
                    end
                    else if (cmd.mode == MODE_CLEAR)
                    begin
                        edges_next = '0;
                        pend_next  = 1'b1;
                        state_next = S_HCLR;
                    end
                end
            end
            S_APP:
            begin
                e_we  = 1'b1;
                fh_we = 1'b1;
                rh_we = 1'b1;
                edges_next = edges_reg + LINK_W'(1);
                state_next = S_DONE;
            end
            S_MCLR:
            begin
                ss_we = 1'b1;
                st_we = 1'b1;
                ss_wa = cnt_reg;
                st_wa = cnt_reg;
                ss_wd = (cnt_reg == a_reg);
                st_wd = (cnt_reg == b_reg);
                qs_we = (cnt_reg == '0);
                qt_we = (cnt_reg == '0);
                qs_wa = '0;
                qt_wa = '0;
                qs_wd = a_reg;
                qt_wd = b_reg;
                cnt_next = cnt_reg + VTX_W'(1);
                if (cnt_reg == '1)
                begin
                    rs_next    = '0;
                    rt_next    = '0;
                    ws_next    = CNT_W'(1);
                    wt_next    = CNT_W'(1);
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                side_next = 1'b0;
                if (rs_reg < ws_reg && rt_reg < wt_reg)
                    state_next = S_NEXT;
                else
                    state_next = S_DONE;
            end
            S_NEXT:
            begin
                if (side_reg)
                    rt_next = rt_reg + CNT_W'(1);
                else
                    rs_next = rs_reg + CNT_W'(1);
                state_next = S_QRD;
            end
            S_QRD:
            begin
                fh_ra = side_reg ? qt_rd : qs_rd;
                rh_ra = side_reg ? qt_rd : qs_rd;
                state_next = S_HRD;
            end
            S_HRD:
            begin
                link_next  = side_reg ? rh_rd : fh_rd;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (link_reg == '0)
                begin
                    if (side_reg)
                        state_next = S_LOOP;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_NEXT;
                    end
                end
                else
                    state_next = S_ERD;
            end
            S_ERD:
            begin
                nb_next    = side_reg ? e_rd.tail : e_rd.head;
                s_ra       = side_reg ? e_rd.tail : e_rd.head;
                link_next  = side_reg ? e_rd.rlink : e_rd.flink;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                if (other_seen)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!mine_seen)
                    begin
                        if (side_reg)
                        begin
                            st_we   = 1'b1;
                            qt_we   = 1'b1;
                            wt_next = wt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ss_we   = 1'b1;
                            qs_we   = 1'b1;
                            ws_next = ws_reg + CNT_W'(1);
                        end
                    end
                    state_next = S_EDGE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    of_next    = found_reg;
                    os_next    = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HCLR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            edges_reg <= '0;
            rs_reg    <= '0;
            ws_reg    <= '0;
            rt_reg    <= '0;
            wt_reg    <= '0;
            side_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            vc_reg    <= 11'(MAX_VERTICES);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            edges_reg <= edges_next;
            rs_reg    <= rs_next;
            ws_reg    <= ws_next;
            rt_reg    <= rt_next;
            wt_reg    <= wt_next;
            side_reg  <= side_next;
            ov_reg    <= ov_next;
            if (vertex_count_we)
                vc_reg <= vertex_count_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        link_reg  <= link_next;
        nb_reg    <= nb_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
        of_reg    <= of_next;
        os_reg    <= os_next;
    end

    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_reg <= LINK_W'(MAX_EDGES))
        else $error("edge count beyond store size");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT) |-> (ws_reg <= CNT_W'(MAX_VERTICES) && wt_reg <= CNT_W'(MAX_VERTICES)))
        else $error("frontier write pointer overflow");

    a_meet_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRD && other_seen) |=> (state_reg == S_DONE && found_reg))
        else $error("meeting point did not report found");

    a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APP) |=> (state_reg == S_DONE && edges_reg == $past(edges_reg) + LINK_W'(1)))
        else $error("append did not advance edge count");

endmodule
